@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a full property
`define SNS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("square note sequencer check failed");

// antecedent followed in the next cycle by consequent
`define SNS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("square note sequencer check failed");

`endif

@@ hdl/sns_pkg.sv @@
package sns_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SLOT_W     = 4;
  localparam int INC_W      = 31;
  localparam int SAMPLE_W   = 16;
  localparam int SPN_W      = 16;
  localparam int COUNT_W    = 5;
  localparam int AMP_W      = 15;
  localparam int ENV_W      = 16;
  localparam int PROD_W     = 32;
  localparam int MAG_PROD_W = AMP_W + ENV_W;
  localparam int Q15_SHIFT  = 15;

  localparam logic [ENV_W-1:0] Q15_ONE = 16'h8000;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_NOTE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_COUNT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_SAMPLES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_SLOPE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SAMPLES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SLOPE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE        = 3'd6;

  typedef struct packed {
    logic [SPN_W-1:0]   samples_per_note;
    logic [COUNT_W-1:0] note_count;
    logic [SPN_W-1:0]   attack_samples;
    logic [ENV_W-1:0]   attack_slope;
    logic [SPN_W-1:0]   release_samples;
    logic [ENV_W-1:0]   release_slope;
    logic [AMP_W-1:0]   amplitude;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    samples_per_note: 16'd5512,
    note_count:       5'd16,
    attack_samples:   16'd220,
    attack_slope:     16'd149,
    release_samples:  16'd441,
    release_slope:    16'd74,
    amplitude:        15'd8000
  };

  function automatic logic [ENV_W-1:0] sat_env(input logic [PROD_W-1:0] prod);
    logic [ENV_W-1:0] env;
    if (prod > PROD_W'(Q15_ONE)) begin
      env = Q15_ONE;
    end else begin
      env = prod[ENV_W-1:0];
    end
    return env;
  endfunction

endpackage

@@ hdl/sns_note_ram.sv @@
module sns_note_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/square_note_sequencer.sv @@
// Load beat: written to the note table in the cycle it is accepted; ready again next cycle.
// Tick beat: sample registered three cycles after accept (table read, slope multiply,
// amplitude multiply), then ready again: four cycles per tick while the output is taken.
// A waiting sample holds the sequencer in its output stage until taken.
// Synchronous active-high reset: registers to defaults, phase, position and sample index
// to zero; note table contents stay undefined until loaded.
`include "assert_macros.svh"

module square_note_sequencer #(
  parameter int NOTE_SLOTS = 16,
  parameter int PHASE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [sns_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sns_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  mode,
  input  logic [sns_pkg::SLOT_W-1:0]            note_slot,
  input  logic [sns_pkg::INC_W-1:0]             note_increment,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [sns_pkg::SAMPLE_W-1:0]   sample,
  output logic                                  phrase_end
);

  import sns_pkg::*;

  localparam int ADDR_W = $clog2(NOTE_SLOTS);
  localparam int CNT_W  = $clog2(NOTE_SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_ENV, S_MAG, S_OUT} state_t;

  state_t                  state;
  cfg_t                    cfg;
  logic [PHASE_BITS-1:0]   phase_acc;
  logic [SPN_W-1:0]        sin_r;
  logic [ADDR_W-1:0]       pos_r;

  logic [INC_W-1:0]        rd_data;
  logic                    tick_acc;
  logic                    load_acc;
  logic                    slot_ok;

  logic [SPN_W-1:0]        spn;
  logic [CNT_W-1:0]        cnt;
  logic                    pos_wrap;
  logic [ADDR_W-1:0]       pos_eff;
  logic [SPN_W-1:0]        sin_eff;

  logic                    rest;
  logic [PHASE_BITS-1:0]   phase_sum;
  logic [SPN_W-1:0]        remaining;
  logic                    note_done;
  logic [CNT_W-1:0]        pos_inc;
  logic                    phrase_done;

  logic [PROD_W-1:0]       prod_att;
  logic [PROD_W-1:0]       prod_rel;
  logic                    att_r;
  logic                    rel_r;
  logic                    rest_r;
  logic                    neg_r;
  logic                    last_r;
  logic [ENV_W-1:0]        env_next;
  logic [MAG_PROD_W-1:0]   mag_prod;
  logic [SAMPLE_W-1:0]     mag;
  logic [SAMPLE_W-1:0]     sample_next;
  logic                    out_load;
  logic                    at_start;

  assign in_ready = (state == S_IDLE);
  assign tick_acc = in_valid && in_ready && (mode == MODE_TICK);
  assign load_acc = in_valid && in_ready && (mode == MODE_LOAD);
  assign slot_ok  = (32'(note_slot) < NOTE_SLOTS);
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);
  assign at_start = (pos_r == '0) && (sin_r == '0) && (phase_acc == '0);

  always_comb begin
    spn = (cfg.samples_per_note == '0) ? SPN_W'(1) : cfg.samples_per_note;
    if (cfg.note_count == '0) begin
      cnt = CNT_W'(1);
    end else if (32'(cfg.note_count) > NOTE_SLOTS) begin
      cnt = CNT_W'(NOTE_SLOTS);
    end else begin
      cnt = CNT_W'(cfg.note_count);
    end
    pos_wrap = (CNT_W'(pos_r) >= cnt);
    pos_eff  = pos_wrap ? '0 : pos_r;
    sin_eff  = (sin_r >= spn) ? (spn - SPN_W'(1)) : sin_r;
  end

  sns_note_ram #(
    .DEPTH  (NOTE_SLOTS),
    .DATA_W (INC_W)
  ) u_note_ram (
    .clk   (clk),
    .we    (load_acc && slot_ok),
    .waddr (ADDR_W'(note_slot)),
    .wdata (note_increment),
    .re    (tick_acc),
    .raddr (pos_eff),
    .rdata (rd_data)
  );

  always_comb begin
    rest        = (rd_data == '0);
    phase_sum   = phase_acc + PHASE_BITS'(rd_data);
    remaining   = spn - sin_r;
    note_done   = ({1'b0, sin_r} + 17'd1) >= {1'b0, spn};
    pos_inc     = CNT_W'(pos_r) + CNT_W'(1);
    phrase_done = note_done && (pos_inc >= cnt);
  end

  always_comb begin
    if (rel_r) begin
      env_next = sat_env(prod_rel);
    end else if (att_r) begin
      env_next = sat_env(prod_att);
    end else begin
      env_next = Q15_ONE;
    end
    mag = mag_prod[MAG_PROD_W-1:Q15_SHIFT];
    if (rest_r) begin
      sample_next = '0;
    end else if (neg_r) begin
      sample_next = SAMPLE_W'(0) - mag;
    end else begin
      sample_next = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cfg       <= CFG_RESET;
      phase_acc <= '0;
      sin_r     <= '0;
      pos_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLES_PER_NOTE: cfg.samples_per_note <= cfg_data;
          REG_NOTE_COUNT:       cfg.note_count       <= cfg_data[COUNT_W-1:0];
          REG_ATTACK_SAMPLES:   cfg.attack_samples   <= cfg_data;
          REG_ATTACK_SLOPE:     cfg.attack_slope     <= cfg_data;
          REG_RELEASE_SAMPLES:  cfg.release_samples  <= cfg_data;
          REG_RELEASE_SLOPE:    cfg.release_slope    <= cfg_data;
          REG_AMPLITUDE:        cfg.amplitude        <= cfg_data[AMP_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (tick_acc) begin
            pos_r <= pos_eff;
            sin_r <= sin_eff;
            if (pos_wrap) begin
              phase_acc <= '0;
            end
            state <= S_ENV;
          end
        end
        S_ENV: begin
          if (phrase_done) begin
            phase_acc <= '0;
          end else if (!rest) begin
            phase_acc <= phase_sum;
          end
          prod_att <= PROD_W'(sin_r) * PROD_W'(cfg.attack_slope);
          prod_rel <= PROD_W'(remaining) * PROD_W'(cfg.release_slope);
          att_r    <= (sin_r < cfg.attack_samples);
          rel_r    <= (remaining < cfg.release_samples);
          rest_r   <= rest;
          neg_r    <= phase_sum[PHASE_BITS-1];
          last_r   <= phrase_done;
          if (note_done) begin
            sin_r <= '0;
            if (phrase_done) begin
              pos_r <= '0;
            end else begin
              pos_r <= ADDR_W'(pos_inc);
            end
          end else begin
            sin_r <= sin_r + SPN_W'(1);
          end
          state <= S_MAG;
        end
        S_MAG: begin
          mag_prod <= MAG_PROD_W'(cfg.amplitude) * MAG_PROD_W'(env_next);
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            sample     <= signed'(sample_next);
            phrase_end <= last_r;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SNS_ASSERT(a_tick_latency, clk, rst, tick_acc |-> ##3 (state == S_OUT))
  `SNS_ASSERT(a_env_in_range, clk, rst, (state == S_ENV) |-> ((sin_r < spn) && (CNT_W'(pos_r) < cnt)))
  `SNS_ASSERT_NEXT(a_phrase_restart, clk, rst, (state == S_ENV) && phrase_done, at_start)
  `SNS_ASSERT_NEXT(a_out_load, clk, rst, out_load, out_valid && (state == S_IDLE))

endmodule

@@ dv/tb_square_note_sequencer.sv @@
`timescale 1ns / 100ps

module tb_square_note_sequencer;
  import sns_pkg::*;

  localparam int PHASE_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic [INC_W-1:0]  inc;
  } note_cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pcm;
    logic                       last;
  } pcm_beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   mode = MODE_TICK;
  logic [SLOT_W-1:0]      note_slot = '0;
  logic [INC_W-1:0]       note_increment = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                   phrase_end;

  square_note_sequencer uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .note_slot      (note_slot),
    .note_increment (note_increment),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample         (sample),
    .phrase_end     (phrase_end)
  );

  // sequencer mirror
  cfg_t               seq_regs = CFG_RESET;
  logic [INC_W-1:0]   note_incs [16];
  logic [PHASE_W-1:0] osc_phase = '0;
  int unsigned        pos_in_note = 0;
  int unsigned        cur_note = 0;

  note_cmd_t note_cmds [$];
  note_cmd_t next_cmd;
  pcm_beat_t due_samples [$];
  pcm_beat_t got_beat;
  int unsigned cmds_pushed = 0;
  int unsigned cmds_taken = 0;
  logic        in_took = 1'b0;
  int          tx_idle = 31;
  int          rx_idle = 62;
  logic        hold_go = 1'b0;
  logic        long_hold = 1'b0;
  int          faults = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic pcm_beat_t synth_tick();
    pcm_beat_t           b;
    int unsigned         spn;
    int unsigned         cnt;
    int unsigned         left;
    longint unsigned     env;
    longint unsigned     mag;
    logic [INC_W-1:0]    step;
    logic [SAMPLE_W-1:0] m16;
    spn = (seq_regs.samples_per_note == 0) ? 1 : seq_regs.samples_per_note;
    cnt = (seq_regs.note_count == 0) ? 1 : seq_regs.note_count;
    if (cnt > 16) cnt = 16;
    if (cur_note >= cnt) begin
      cur_note = 0;
      osc_phase = '0;
    end
    if (pos_in_note >= spn) pos_in_note = spn - 1;
    step = note_incs[cur_note];
    b.pcm = '0;
    if (step != '0) begin
      osc_phase = osc_phase + step;
      env = Q15_ONE;
      if (pos_in_note < seq_regs.attack_samples) begin
        env = pos_in_note;
        env = env * seq_regs.attack_slope;
        if (env > Q15_ONE) env = Q15_ONE;
      end
      left = spn - pos_in_note;
      if (left < seq_regs.release_samples) begin
        env = left;
        env = env * seq_regs.release_slope;
        if (env > Q15_ONE) env = Q15_ONE;
      end
      mag = (env * seq_regs.amplitude) >> Q15_SHIFT;
      m16 = SAMPLE_W'(mag);
      b.pcm = osc_phase[PHASE_W-1] ? -m16 : m16;
    end
    b.last = (cur_note == cnt - 1) && (pos_in_note == spn - 1);
    if (pos_in_note + 1 >= spn) begin
      pos_in_note = 0;
      cur_note++;
      if (cur_note >= cnt) begin
        cur_note = 0;
        osc_phase = '0;
      end
    end else begin
      pos_in_note++;
    end
    return b;
  endfunction

  task automatic report_fault(input string msg);
    faults++;
    if (faults <= 10) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    in_took <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      cmds_taken++;
      if (mode == MODE_LOAD) begin
        note_incs[note_slot] = note_increment;
      end else begin
        due_samples.push_back(synth_tick());
      end
    end
    if (!rst && out_valid && out_ready) begin
      if (due_samples.size() == 0) begin
        report_fault($sformatf("sample %0d arrived with nothing pending", sample));
      end else begin
        got_beat = due_samples.pop_front();
        if (sample !== got_beat.pcm)
          report_fault($sformatf("sample mismatch: expected %0d, got %0d",
                                 got_beat.pcm, sample));
        if (phrase_end !== got_beat.last)
          report_fault($sformatf("phrase_end mismatch: expected %0b, got %0b",
                                 got_beat.last, phrase_end));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (note_cmds.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
        next_cmd = note_cmds.pop_front();
        in_valid <= 1'b1;
        mode <= next_cmd.mode;
        note_slot <= next_cmd.slot;
        note_increment <= next_cmd.inc;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !long_hold && ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // hold the output while the sender keeps offering beats
  initial begin
    wait (hold_go);
    @(negedge clk);
    long_hold <= 1'b1;
    repeat (300) @(negedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic queue_tick();
    note_cmds.push_back(note_cmd_t'{MODE_TICK, SLOT_W'($urandom), INC_W'($urandom)});
    cmds_pushed++;
  endtask

  task automatic queue_load(input logic [SLOT_W-1:0] slot, input logic [INC_W-1:0] inc);
    note_cmds.push_back(note_cmd_t'{MODE_LOAD, slot, inc});
    cmds_pushed++;
  endtask

  task automatic settle();
    while (cmds_taken != cmds_pushed || due_samples.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_SAMPLES_PER_NOTE: seq_regs.samples_per_note = data;
      REG_NOTE_COUNT:       seq_regs.note_count = data[COUNT_W-1:0];
      REG_ATTACK_SAMPLES:   seq_regs.attack_samples = data;
      REG_ATTACK_SLOPE:     seq_regs.attack_slope = data;
      REG_RELEASE_SAMPLES:  seq_regs.release_samples = data;
      REG_RELEASE_SLOPE:    seq_regs.release_slope = data;
      REG_AMPLITUDE:        seq_regs.amplitude = data[AMP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(input logic [15:0] spn, input logic [15:0] cnt,
                              input logic [15:0] atk_n, input logic [15:0] atk_s,
                              input logic [15:0] rel_n, input logic [15:0] rel_s,
                              input logic [15:0] amp);
    write_reg(REG_SAMPLES_PER_NOTE, spn);
    write_reg(REG_NOTE_COUNT, cnt);
    write_reg(REG_ATTACK_SAMPLES, atk_n);
    write_reg(REG_ATTACK_SLOPE, atk_s);
    write_reg(REG_RELEASE_SAMPLES, rel_n);
    write_reg(REG_RELEASE_SLOPE, rel_s);
    write_reg(REG_AMPLITUDE, amp);
  endtask

  initial begin
    int unsigned      spn;
    int unsigned      n_items;
    logic [INC_W-1:0] inc;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill every slot before the first tick
    queue_load(4'd0, 31'h7FFF_FFFF);
    queue_load(4'd1, '0);
    queue_load(4'd2, 31'h4000_0000);
    queue_load(4'd3, 31'd1);
    for (int s = 4; s < 16; s++) queue_load(SLOT_W'(s), INC_W'($urandom));
    queue_tick();
    queue_tick();
    settle();

    write_reg(REG_UNUSED, 16'hFFFF);
    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd32767);
    queue_tick();
    queue_tick();
    settle();

    program_regs(16'd2, 16'd31, 16'd0, 16'd0, 16'd0, 16'd0, 16'd32767);
    repeat (3) queue_tick();
    settle();

    for (int k = 0; k < 10; k++) begin
      case (k)
        0: program_regs(16'd4, 16'd3, 16'd2, 16'h8000, 16'd2, 16'h4000, 16'd32767);
        1: program_regs(16'd1, 16'd16, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        2: program_regs(16'hFFFF, 16'd2, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 16'd32767);
        3: program_regs(16'd7, 16'hFFE0, 16'd3, 16'hFFFF, 16'd3, 16'hFFFF,
                        16'h8000 | 16'd12345);
        4: program_regs(16'd0, 16'd31, 16'hFFFF, 16'h8000, 16'd0, 16'h8000, 16'hFFFF);
        default: begin
          spn = (k == 6) ? $urandom_range(200, 600) : $urandom_range(1, 12);
          program_regs(16'(spn), 16'($urandom), 16'($urandom_range(0, spn + 2)),
                       16'($urandom_range(0, 40000)), 16'($urandom_range(0, spn + 2)),
                       16'($urandom_range(0, 40000)), 16'($urandom));
        end
      endcase
      if (k >= 7) begin
        tx_idle <= 0;
        rx_idle <= 0;
      end else if (k >= 4) begin
        tx_idle <= 62;
        rx_idle <= 31;
      end
      n_items = (k == 2) ? 40 : 132;
      repeat (n_items) begin
        if ($urandom_range(0, 99) < 15) begin
          case ($urandom_range(0, 3))
            0:       inc = '0;
            1:       inc = 31'h7FFF_FFFF;
            2:       inc = INC_W'($urandom_range(1, 1000));
            default: inc = INC_W'($urandom);
          endcase
          queue_load(SLOT_W'($urandom), inc);
        end else begin
          queue_tick();
        end
      end
      if (k == 8) hold_go <= 1'b1;
      settle();
    end

    if (faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/sns_pkg.sv
hdl/sns_note_ram.sv
hdl/square_note_sequencer.sv
dv/tb_square_note_sequencer.sv
